### design/mars_pkg.sv
// package for the multi-alarm reminder sequencer
// widths, codes, state machine states and transaction structs
// no dependencies
`timescale 1ns / 1ps

package mars_pkg;

    // table size
    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // field widths
    localparam int CMD_W     = 2;
    localparam int EIDX_W    = 6;
    localparam int OFFSET_W  = 22;
    localparam int ECOUNT_W  = 7;
    localparam int MS_W      = 32;
    localparam int DUR_W     = 20;
    localparam int MODE_W    = 2;
    localparam int ANSWER_W  = 2;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_W   = 1;

    localparam logic [DUR_W-1:0] VIBRATE_RESET = DUR_W'(5000);
    localparam logic [DUR_W-1:0] TIMEOUT_RESET = DUR_W'(15000);
    localparam logic [MS_W-1:0]  MS_PER_S      = MS_W'(1000);

    typedef enum logic [REG_W-1:0] {
        REG_VIBRATE = 1'b0,
        REG_TIMEOUT = 1'b1
    } t_reg;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_START = 2'd2
    } t_cmd;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE = 2'd0,
        MODE_PROC = 2'd1,
        MODE_VIB  = 2'd2,
        MODE_WAIT = 2'd3
    } t_mode;

    typedef enum logic [ANSWER_W-1:0] {
        ANS_NONE = 2'd0,
        ANS_YES  = 2'd1,
        ANS_NO   = 2'd2
    } t_answer;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_CLEAR,
        FSM_SCAN,
        FSM_DRAIN,
        FSM_RESOLVE,
        FSM_PUBLISH
    } t_fsm;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [EIDX_W-1:0]   entry_index;
        logic [OFFSET_W-1:0] offset_seconds;
        logic [ECOUNT_W-1:0] entry_count;
        logic                button_level;
    } t_item;

    typedef struct packed {
        logic                motor_on;
        logic [MODE_W-1:0]   mode;
        logic [EIDX_W-1:0]   active_entry;
        logic [MS_W-1:0]     next_due_ms;
        logic [ANSWER_W-1:0] answer_event;
        logic [EIDX_W-1:0]   answer_entry;
        logic                all_done;
    } t_result;

endpackage

### design/mars_if.sv
// channel interfaces: command transactions in, status transactions out
// depends on mars_pkg
`timescale 1ns / 1ps

interface mars_item_if;
    import mars_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [EIDX_W-1:0]   entry_index;
    logic [OFFSET_W-1:0] offset_seconds;
    logic [ECOUNT_W-1:0] entry_count;
    logic                button_level;

    modport source (
        output valid, cmd, entry_index, offset_seconds, entry_count, button_level,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry_index, offset_seconds, entry_count, button_level,
        output ready
    );
endinterface

interface mars_result_if;
    import mars_pkg::*;

    logic                valid;
    logic                ready;
    logic                motor_on;
    logic [MODE_W-1:0]   mode;
    logic [EIDX_W-1:0]   active_entry;
    logic [MS_W-1:0]     next_due_ms;
    logic [ANSWER_W-1:0] answer_event;
    logic [EIDX_W-1:0]   answer_entry;
    logic                all_done;

    modport source (
        output valid, motor_on, mode, active_entry, next_due_ms, answer_event,
               answer_entry, all_done,
        input  ready
    );
    modport sink (
        input  valid, motor_on, mode, active_entry, next_due_ms, answer_event,
               answer_entry, all_done,
        output ready
    );
endinterface

### design/mars_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module mars_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### design/multi_alarm_reminder_sequencer.sv
// top level of the multi-alarm reminder sequencer
// depends on mars_pkg, mars_if (mars_item_if, mars_result_if) and mars_ram
`timescale 1ns / 1ps

// Usage
// i_item carries one command per transaction: a millisecond tick, a table
// write (entry_index, offset_seconds) or a schedule start (entry_count).
// Every command transaction yields exactly one status transaction on
// o_result. Timing registers vibrate_ms and answer_timeout_ms sit on the
// APB port at byte addresses 0 and 4; write them only while the block idles.
// A write, a tick outside the processing mode or a tick with no entry in
// use passes the execute and publish states before its status is registered.
// A start sweeps the pending marks in the status ram, one entry per cycle
// over all 64 entries, before it publishes its status. A tick in the
// processing mode scans the table: one read of both rams per entry in use,
// then the pipeline drains (multiply, add and compare) and a resolve step
// follows; each ram has a single read port, so the entries are read one
// after another. A new command is taken only once the previous one has
// reached the output register stage, so commands are not overlapped but
// for the one described below.
// If the receiver stalls, the finished status waits in the output register;
// one further command is still taken and processed, then held until the
// output register is free.
// Reset: synchronous, active low; clears mode, timers and the result valid
// flag. Neither ram is cleared: the offset table needs no sweep and every
// start sweeps the pending marks before they are read.

module multi_alarm_reminder_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mars_item_if.sink                      i_item,
    mars_result_if.source                  o_result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mars_pkg::PADDR_W-1:0]   paddr,
    input  logic [mars_pkg::PDATA_W-1:0]   pwdata,
    output logic [mars_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import mars_pkg::*;

    // configuration registers
    logic [DUR_W-1:0] r_vib;
    logic [DUR_W-1:0] r_timeout;
    t_reg             reg_sel;

    // control and schedule state
    t_fsm                  r_fsm, n_fsm;
    t_item                 r_item, n_item;
    t_mode                 r_mode, n_mode;
    logic [CNT_W-1:0]      r_used, n_used;
    logic                  r_loaded, n_loaded;
    logic [MS_W-1:0]       r_now, n_now;
    logic [MS_W-1:0]       r_start, n_start;
    logic [MS_W-1:0]       r_phase, n_phase;
    logic [IDX_W-1:0]      r_cur, n_cur;
    logic                  r_cur_valid, n_cur_valid;
    logic [MS_W-1:0]       r_earliest, n_earliest;
    t_answer               r_ev, n_ev;
    logic [EIDX_W-1:0]     r_ent, n_ent;
    logic                  r_done, n_done;

    // scan sequencer and pipeline
    logic [IDX_W-1:0]      r_rd_idx, n_rd_idx;
    logic                  r_drain, n_drain;
    logic                  r_s0_v, r_s1_v;
    logic [IDX_W-1:0]      r_s0_idx, r_s1_idx;
    logic [MS_W-1:0]       r_prod;
    logic [MS_W-1:0]       s2_due;
    logic                  r_found, n_found;
    logic [MS_W-1:0]       r_best, n_best;
    logic [IDX_W-1:0]      r_best_idx, n_best_idx;

    // output register
    t_result               r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    // offset ram ports
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [OFFSET_W-1:0]   ram_wdata;
    logic [OFFSET_W-1:0]   ram_rdata;

    // status ram ports, 1 marks an answered entry
    logic                  stat_we;
    logic [IDX_W-1:0]      stat_waddr;
    logic                  stat_wdata;
    logic                  stat_rdata;

    // helpers
    logic                  in_fire;
    logic [MS_W-1:0]       elapsed;
    logic                  rec_ok;
    logic                  do_rec;
    t_answer               answer;
    logic                  scan_last;

    mars_ram #(
        .WIDTH (OFFSET_W),
        .DEPTH (MAX_ENTRIES)
    ) u_offset_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    mars_ram #(
        .WIDTH (1),
        .DEPTH (MAX_ENTRIES)
    ) u_status_ram (
        .i_clk   (i_clk),
        .i_we    (stat_we),
        .i_waddr (stat_waddr),
        .i_wdata (stat_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (stat_rdata)
    );

    // apb register access
    assign pready  = 1'b1;
    assign reg_sel = t_reg'(paddr[PADDR_W-1:2]);

    always_comb begin
        case (reg_sel)
            REG_VIBRATE: prdata = PDATA_W'(r_vib);
            REG_TIMEOUT: prdata = PDATA_W'(r_timeout);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vib     <= VIBRATE_RESET;
            r_timeout <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                REG_VIBRATE: r_vib     <= pwdata[DUR_W-1:0];
                REG_TIMEOUT: r_timeout <= pwdata[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    // channel handshakes
    assign i_item.ready = (r_fsm == FSM_IDLE);
    assign in_fire      = i_item.valid && i_item.ready;

    assign o_result.valid        = r_out_valid;
    assign o_result.motor_on     = r_out.motor_on;
    assign o_result.mode         = r_out.mode;
    assign o_result.active_entry = r_out.active_entry;
    assign o_result.next_due_ms  = r_out.next_due_ms;
    assign o_result.answer_event = r_out.answer_event;
    assign o_result.answer_entry = r_out.answer_entry;
    assign o_result.all_done     = r_out.all_done;

    // phase timer and answer recording conditions
    assign elapsed   = r_now - r_phase;
    assign rec_ok    = r_loaded && r_cur_valid && (CNT_W'(r_cur) < r_used);
    assign answer    = r_item.button_level ? ANS_YES : ANS_NO;
    assign do_rec    = r_item.button_level || (elapsed >= MS_W'(r_timeout));
    assign scan_last = (CNT_W'(r_rd_idx) == (r_used - CNT_W'(1)));
    assign s2_due    = r_start + r_prod;

    // ram write port follows the held write transaction
    assign ram_waddr = IDX_W'(r_item.entry_index);
    assign ram_wdata = r_item.offset_seconds;

    // sequencer next state and state updates
    always_comb begin
        n_fsm       = r_fsm;
        n_item      = r_item;
        n_mode      = r_mode;
        n_used      = r_used;
        n_loaded    = r_loaded;
        n_now       = r_now;
        n_start     = r_start;
        n_phase     = r_phase;
        n_cur       = r_cur;
        n_cur_valid = r_cur_valid;
        n_earliest  = r_earliest;
        n_ev        = r_ev;
        n_ent       = r_ent;
        n_done      = r_done;
        n_rd_idx    = r_rd_idx;
        n_drain     = r_drain;
        n_found     = r_found;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_result.ready;
        ram_we      = 1'b0;
        stat_we     = 1'b0;
        stat_waddr  = r_cur;
        stat_wdata  = 1'b1;

        // earliest-due compare stage, first index wins a tie
        if (r_s1_v && (!r_found || (s2_due < r_best))) begin
            n_found    = 1'b1;
            n_best     = s2_due;
            n_best_idx = r_s1_idx;
        end

        case (r_fsm)
            FSM_IDLE: begin
                if (in_fire) begin
                    n_item.cmd            = i_item.cmd;
                    n_item.entry_index    = i_item.entry_index;
                    n_item.offset_seconds = i_item.offset_seconds;
                    n_item.entry_count    = i_item.entry_count;
                    n_item.button_level   = i_item.button_level;
                    if (t_cmd'(i_item.cmd) == CMD_TICK) begin
                        n_now = r_now + MS_W'(1);
                    end
                    n_fsm = FSM_EXEC;
                end
            end

            FSM_EXEC: begin
                n_ev   = ANS_NONE;
                n_ent  = '0;
                n_done = 1'b0;
                n_fsm  = FSM_PUBLISH;
                case (t_cmd'(r_item.cmd))
                    CMD_TICK: begin
                        case (r_mode)
                            MODE_PROC: begin
                                if (!r_loaded) begin
                                    n_mode = MODE_IDLE;
                                end else if (r_used == '0) begin
                                    n_earliest = '0;
                                    n_done     = 1'b1;
                                    n_mode     = MODE_IDLE;
                                end else begin
                                    n_found  = 1'b0;
                                    n_rd_idx = '0;
                                    n_fsm    = FSM_SCAN;
                                end
                            end
                            MODE_VIB: begin
                                if (elapsed >= MS_W'(r_vib)) begin
                                    n_phase = r_now;
                                    n_mode  = MODE_WAIT;
                                end
                            end
                            MODE_WAIT: begin
                                if (do_rec) begin
                                    if (rec_ok) begin
                                        stat_we = 1'b1;
                                        n_ev    = answer;
                                        n_ent   = EIDX_W'(r_cur);
                                        n_mode  = MODE_PROC;
                                    end else begin
                                        n_mode = MODE_IDLE;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                    CMD_WRITE: begin
                        if (32'(r_item.entry_index) < 32'(MAX_ENTRIES)) begin
                            ram_we = 1'b1;
                        end
                    end
                    CMD_START: begin
                        if (32'(r_item.entry_count) > 32'(MAX_ENTRIES)) begin
                            n_used = CNT_W'(MAX_ENTRIES);
                        end else begin
                            n_used = CNT_W'(r_item.entry_count);
                        end
                        n_start     = r_now;
                        n_loaded    = 1'b1;
                        n_cur       = '0;
                        n_cur_valid = 1'b0;
                        n_mode      = MODE_PROC;
                        n_rd_idx    = '0;
                        n_fsm       = FSM_CLEAR;
                    end
                    default: ;
                endcase
            end

            // sweep the pending marks, one entry per cycle
            FSM_CLEAR: begin
                stat_we    = 1'b1;
                stat_waddr = r_rd_idx;
                stat_wdata = 1'b0;
                n_rd_idx   = r_rd_idx + IDX_W'(1);
                if (r_rd_idx == IDX_W'(MAX_ENTRIES - 1)) begin
                    n_fsm = FSM_PUBLISH;
                end
            end

            // one ram read per entry in use
            FSM_SCAN: begin
                n_rd_idx = r_rd_idx + IDX_W'(1);
                if (scan_last) begin
                    n_drain = 1'b0;
                    n_fsm   = FSM_DRAIN;
                end
            end

            // let the multiply and compare stages empty
            FSM_DRAIN: begin
                if (r_drain) begin
                    n_fsm = FSM_RESOLVE;
                end else begin
                    n_drain = 1'b1;
                end
            end

            FSM_RESOLVE: begin
                if (r_found) begin
                    if (r_now >= r_best) begin
                        n_cur       = r_best_idx;
                        n_cur_valid = 1'b1;
                        n_phase     = r_now;
                        n_mode      = MODE_VIB;
                    end
                    n_earliest = r_best;
                end else begin
                    n_earliest = '0;
                    n_done     = 1'b1;
                    n_mode     = MODE_IDLE;
                end
                n_fsm = FSM_PUBLISH;
            end

            // hand the status to the output register once it is free
            FSM_PUBLISH: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out.motor_on     = (r_mode == MODE_VIB);
                    n_out.mode         = r_mode;
                    n_out.active_entry = ((r_mode == MODE_VIB) || (r_mode == MODE_WAIT)) ?
                                         EIDX_W'(r_cur) : '0;
                    n_out.next_due_ms  = r_earliest;
                    n_out.answer_event = r_ev;
                    n_out.answer_entry = r_ent;
                    n_out.all_done     = r_done;
                    n_out_valid        = 1'b1;
                    n_fsm              = FSM_IDLE;
                end
            end

            default: n_fsm = FSM_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= FSM_IDLE;
        end else begin
            r_fsm <= n_fsm;
        end
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_used      <= '0;
            r_loaded    <= 1'b0;
            r_now       <= '0;
            r_start     <= '0;
            r_phase     <= '0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_earliest  <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_s0_v      <= 1'b0;
            r_s1_v      <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_used      <= n_used;
            r_loaded    <= n_loaded;
            r_now       <= n_now;
            r_start     <= n_start;
            r_phase     <= n_phase;
            r_cur       <= n_cur;
            r_cur_valid <= n_cur_valid;
            r_earliest  <= n_earliest;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            r_s0_v      <= (r_fsm == FSM_SCAN);
            r_s1_v      <= r_s0_v && !stat_rdata;
        end
    end

    // payload registers and scan datapath
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_ev       <= n_ev;
        r_ent      <= n_ent;
        r_done     <= n_done;
        r_rd_idx   <= n_rd_idx;
        r_drain    <= n_drain;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_out      <= n_out;
        r_s0_idx   <= r_rd_idx;
        r_s1_idx   <= r_s0_idx;
        r_prod     <= MS_W'(MS_W'(ram_rdata) * MS_PER_S);
    end

    // scan pipeline only carries entries while a scan is running
    a_scan_confined: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v |-> ((r_fsm == FSM_SCAN) || (r_fsm == FSM_DRAIN)))
        else $error("scan pipeline active outside a scan");

    // an accepted command is always executed in the following cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> (r_fsm == FSM_EXEC))
        else $error("accepted command not executed");

    // a recorded answer always returns the block to processing
    a_answer_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.answer_event != ANS_NONE)) |->
            (r_out.mode == MODE_PROC))
        else $error("answer recorded outside processing");

    // a finished schedule reports idle and no due time
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.all_done) |->
            ((r_out.mode == MODE_IDLE) && (r_out.next_due_ms == '0)))
        else $error("done reported with pending work");

endmodule

### tb/sv/multi_alarm_reminder_sequencer_tb.sv
// self-checking testbench for the multi-alarm reminder sequencer
// drives command transactions, predicts every status transaction, checks them in order
// depends on mars_pkg, mars_if and multi_alarm_reminder_sequencer
`timescale 1ns / 1ps

module multi_alarm_reminder_sequencer_tb;
    import mars_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int OFFSET_TOP    = (1 << OFFSET_W) - 1;
    localparam int DUR_TOP       = (1 << DUR_W) - 1;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 100;
    localparam int REPORT_LIMIT  = 10;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    mars_item_if   item_ch ();
    mars_result_if status_ch ();

    multi_alarm_reminder_sequencer uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (status_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predicted sequencer state and timing registers
    logic [DUR_W-1:0]    vib_ms = VIBRATE_RESET;
    logic [DUR_W-1:0]    tmo_ms = TIMEOUT_RESET;
    logic [OFFSET_W-1:0] tbl_offset [MAX_ENTRIES];
    t_answer             tbl_answer [MAX_ENTRIES];
    int unsigned         used_cnt     = 0;
    bit                  sched_loaded = 0;
    logic [MS_W-1:0]     clock_ms     = '0;
    logic [MS_W-1:0]     sched_start  = '0;
    logic [MS_W-1:0]     phase_start  = '0;
    logic [MS_W-1:0]     earliest     = '0;
    t_mode               mode_q       = MODE_IDLE;
    logic [EIDX_W-1:0]   cur_entry    = '0;
    bit                  cur_valid    = 0;

    // command backlog, outstanding statuses and run control
    t_item   cmd_backlog [$];
    t_result status_due [$];
    t_item   offered;
    t_result seen;
    bit      item_taken     = 0;
    int      item_total     = 0;
    int      mismatches     = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    int      hold_req       = 0;
    int      hold_ack       = 0;
    int      hold_left      = 0;

    // status after one command, advancing the predicted state
    function automatic t_result sequencer_status(input t_item it);
        t_result         r;
        logic [MS_W-1:0] due;
        logic [MS_W-1:0] best;
        int              best_idx;
        bit              found;
        t_answer         ans;
        r        = '0;
        best     = '0;
        best_idx = 0;
        found    = 0;
        case (it.cmd)
            CMD_TICK: begin
                clock_ms = clock_ms + 1;
                case (mode_q)
                    MODE_PROC: begin
                        if (!sched_loaded) begin
                            mode_q = MODE_IDLE;
                        end else begin
                            // earliest pending due time, lowest index on a tie
                            for (int i = 0; i < int'(used_cnt); i++) begin
                                if (tbl_answer[i] == ANS_NONE) begin
                                    due = sched_start + MS_W'(tbl_offset[i]) * MS_PER_S;
                                    if (!found || due < best) begin
                                        best     = due;
                                        best_idx = i;
                                        found    = 1;
                                    end
                                end
                            end
                            if (found) begin
                                if (clock_ms >= best) begin
                                    cur_entry   = EIDX_W'(best_idx);
                                    cur_valid   = 1;
                                    phase_start = clock_ms;
                                    mode_q      = MODE_VIB;
                                end
                                earliest = best;
                            end else begin
                                earliest   = '0;
                                r.all_done = 1'b1;
                                mode_q     = MODE_IDLE;
                            end
                        end
                    end
                    MODE_VIB: begin
                        if (clock_ms - phase_start >= MS_W'(vib_ms)) begin
                            phase_start = clock_ms;
                            mode_q      = MODE_WAIT;
                        end
                    end
                    MODE_WAIT: begin
                        if (it.button_level || clock_ms - phase_start >= MS_W'(tmo_ms)) begin
                            ans = it.button_level ? ANS_YES : ANS_NO;
                            if (!sched_loaded || !cur_valid || cur_entry >= used_cnt) begin
                                mode_q = MODE_IDLE;
                            end else begin
                                tbl_answer[cur_entry] = ans;
                                r.answer_event        = ans;
                                r.answer_entry        = cur_entry;
                                mode_q                = MODE_PROC;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_WRITE: begin
                tbl_offset[it.entry_index] = it.offset_seconds;
            end
            CMD_START: begin
                used_cnt = (it.entry_count > MAX_ENTRIES) ? MAX_ENTRIES : it.entry_count;
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    tbl_answer[i] = ANS_NONE;
                end
                sched_start  = clock_ms;
                sched_loaded = 1;
                cur_entry    = '0;
                cur_valid    = 0;
                mode_q       = MODE_PROC;
            end
            default: begin
            end
        endcase
        r.motor_on     = (mode_q == MODE_VIB);
        r.mode         = mode_q;
        r.active_entry = (mode_q == MODE_VIB || mode_q == MODE_WAIT) ? cur_entry : '0;
        r.next_due_ms  = earliest;
        return r;
    endfunction

    // compare one status transaction with the oldest prediction
    task automatic check_status(input t_result got);
        t_result want;
        if (status_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%0t: status transaction with none outstanding, got mode %0d due %h",
                         $time, got.mode, got.next_due_ms);
            end
        end else begin
            want = status_due.pop_front();
            if (got.motor_on !== want.motor_on || got.mode !== want.mode ||
                got.active_entry !== want.active_entry ||
                got.next_due_ms !== want.next_due_ms ||
                got.answer_event !== want.answer_event ||
                got.answer_entry !== want.answer_entry ||
                got.all_done !== want.all_done) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display({"%0t: status mismatch, exp motor %0d mode %0d active %0d",
                              " due %h ans %0d/%0d done %0d"},
                             $time, want.motor_on, want.mode, want.active_entry,
                             want.next_due_ms, want.answer_event, want.answer_entry,
                             want.all_done);
                    $display({"        got motor %0d mode %0d active %0d due %h",
                              " ans %0d/%0d done %0d"},
                             got.motor_on, got.mode, got.active_entry, got.next_due_ms,
                             got.answer_event, got.answer_entry, got.all_done);
                end
            end
        end
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // command driver, fed from the backlog
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else if (!item_ch.valid || item_taken) begin
            if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                offered = cmd_backlog.pop_front();
                item_ch.valid          <= 1'b1;
                item_ch.cmd            <= offered.cmd;
                item_ch.entry_index    <= offered.entry_index;
                item_ch.offset_seconds <= offered.offset_seconds;
                item_ch.entry_count    <= offered.entry_count;
                item_ch.button_level   <= offered.button_level;
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // status receiver, random stalls plus the long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            status_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            status_ch.ready <= 1'b0;
        end else if (hold_ack != hold_req) begin
            hold_ack  = hold_ack + 1;
            hold_left = HOLD_CYCLES;
            status_ch.ready <= 1'b0;
        end else begin
            status_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor: check statuses, predict on each accepted command
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_taken <= 1'b0;
        end else begin
            if (status_ch.valid && status_ch.ready) begin
                seen.motor_on     = status_ch.motor_on;
                seen.mode         = status_ch.mode;
                seen.active_entry = status_ch.active_entry;
                seen.next_due_ms  = status_ch.next_due_ms;
                seen.answer_event = status_ch.answer_event;
                seen.answer_entry = status_ch.answer_entry;
                seen.all_done     = status_ch.all_done;
                check_status(seen);
            end
            item_taken <= item_ch.valid && item_ch.ready;
            if (item_ch.valid && item_ch.ready) begin
                status_due.push_back(sequencer_status(offered));
            end
        end
    end

    // command builders
    task automatic push_item(input logic [CMD_W-1:0] c, input int idx, input int off,
                             input int cnt, input bit btn);
        t_item it;
        it                = '0;
        it.cmd            = c;
        it.entry_index    = EIDX_W'(idx);
        it.offset_seconds = OFFSET_W'(off);
        it.entry_count    = ECOUNT_W'(cnt);
        it.button_level   = btn;
        cmd_backlog.push_back(it);
        if (c != CMD_UNUSED) begin
            item_total++;
        end
    endtask

    task automatic push_tick(input bit btn);
        push_item(CMD_TICK, $urandom_range(0, 63), $urandom_range(0, OFFSET_TOP),
                  $urandom_range(0, 127), btn);
    endtask

    task automatic push_write(input int idx, input int off);
        push_item(CMD_WRITE, idx, off, $urandom_range(0, 127), $urandom_range(0, 1));
    endtask

    task automatic push_start(input int cnt);
        push_item(CMD_START, $urandom_range(0, 63), $urandom_range(0, OFFSET_TOP), cnt,
                  $urandom_range(0, 1));
    endtask

    // half due at once, some one or two seconds out, some far away
    function automatic int random_offset();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 65) return $urandom_range(1, 2);
        if (p < 75) return OFFSET_TOP;
        return $urandom_range(0, OFFSET_TOP);
    endfunction

    // entry counts, saturating ones included
    function automatic int random_count();
        int p;
        p = $urandom_range(0, 99);
        if (p < 8)  return 0;
        if (p < 60) return $urandom_range(1, 6);
        if (p < 82) return $urandom_range(7, 63);
        if (p < 92) return MAX_ENTRIES;
        return $urandom_range(MAX_ENTRIES + 1, 127);
    endfunction

    // random traffic, mostly complete schedules, the rest noise
    task automatic gen_traffic(input int n);
        int target;
        int pick;
        int cnt;
        int top;
        int run_len;
        int press_pct;
        target = item_total + n;
        while (item_total < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                cnt = random_count();
                top = ((cnt > MAX_ENTRIES) ? MAX_ENTRIES : cnt) - 1;
                repeat ($urandom_range(0, (cnt < 6) ? cnt : 6)) begin
                    push_write($urandom_range(0, top), random_offset());
                end
                push_start(cnt);
                run_len   = $urandom_range(6, 50);
                press_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
                repeat (run_len) begin
                    push_tick($urandom_range(0, 99) < press_pct);
                end
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 12)) begin
                    push_tick($urandom_range(0, 1));
                end
            end else if (pick < 93) begin
                push_start(random_count());
            end else if (pick < 97) begin
                push_write($urandom_range(0, 63), random_offset());
            end else begin
                push_item(CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, OFFSET_TOP),
                          $urandom_range(0, 127), $urandom_range(0, 1));
            end
        end
    endtask

    // until every command is accepted and every status has come back
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (cmd_backlog.size() != 0 || item_ch.valid || status_due.size() != 0);
    endtask

    // apb write of one timing register, then read it back
    task automatic set_timing(input t_reg r, input int v);
        if (r == REG_VIBRATE) begin
            vib_ms = DUR_W'(v);
        end else begin
            tmo_ms = DUR_W'(v);
        end
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'(4 * int'(r));
        pwdata  = PDATA_W'(v);
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata !== PDATA_W'(v)) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%0t: register %s read back %h, exp %h", $time, r.name(), prdata,
                         PDATA_W'(v));
            end
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // one phase of random traffic under one timing setting and idling mix
    task automatic run_phase(input int vib, input int tmo, input int idle_pct,
                             input int stall_pct, input int n, input bit with_hold);
        wait_idle();
        set_timing(REG_VIBRATE, vib);
        set_timing(REG_TIMEOUT, tmo);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (with_hold) begin
            hold_req++;
        end
        gen_traffic(n);
        wait_idle();
    endtask

    // stimulus and end of run
    initial begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            tbl_offset[i] = '0;
            tbl_answer[i] = ANS_NONE;
        end
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset timing: idle tick, unknown command, empty schedule,
        // tie on equal due times, restart while the motor runs
        push_tick(1'b0);
        push_item(CMD_UNUSED, 63, OFFSET_TOP, 127, 1'b1);
        push_start(0);
        push_tick(1'b0);
        push_write(0, 0);
        push_write(1, 0);
        push_write(2, OFFSET_TOP);
        push_write(63, 0);
        push_start(3);
        push_tick(1'b1);
        push_tick(1'b0);
        push_start(3);
        push_tick(1'b0);
        wait_idle();

        // directed, short timing: write while waiting, yes answer, timeout,
        // alarm far away, second schedule
        set_timing(REG_VIBRATE, 1);
        set_timing(REG_TIMEOUT, 2);
        push_tick(1'b0);
        push_write(1, 0);
        push_tick(1'b1);
        push_tick(1'b0);
        push_tick(1'b0);
        push_tick(1'b0);
        push_tick(1'b0);
        push_tick(1'b0);
        push_tick(1'b1);
        push_start(2);
        push_tick(1'b0);

        // fill the whole table so any count can be started
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            push_write(i, random_offset());
        end

        run_phase(DUR_TOP, DUR_TOP, 0, 0, 60, 1'b0);
        run_phase(2, 3, 69, 0, 320, 1'b0);
        run_phase(0, 0, 0, 69, 300, 1'b0);
        run_phase(1, 1, 28, 28, 320, 1'b0);
        run_phase(4, 9, 0, 0, 300, 1'b1);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && status_due.size() == 0) begin
            $display("[multi_alarm_reminder_sequencer] OK");
        end else begin
            $display("[multi_alarm_reminder_sequencer] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #50_000_000;
        $display("[multi_alarm_reminder_sequencer] ERROR");
        $finish;
    end

endmodule
